FILE: hdl/htw_pkg.sv
// Package: sizes, codes and the slot record of the hashed timing wheel.
`default_nettype none
package htw_pkg;

    // Wheel and pool sizes (both powers of two)
    localparam int BKT_W       = 7;
    localparam int BUCKETS     = 1 << BKT_W;
    localparam int SLOT_W      = 5;
    localparam int EVENT_SLOTS = 1 << SLOT_W;
    localparam int LINK_W      = SLOT_W + 1;
    localparam int DELTA_W     = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int GUARD_W     = $clog2(EVENT_SLOTS + 1);

    // Field widths
    localparam int TICK_W   = 10;
    localparam int DELAY_W  = 32;
    localparam int NUM_W    = DELAY_W + 1;
    localparam int HALF_W   = 19;
    localparam int DEN_W    = 20;
    localparam int STEP_W   = $clog2(NUM_W);
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);
    localparam int HALF_MS = 500;

    // Request codes
    typedef enum logic [1:0] {
        REQ_SCHED  = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_FIRED     = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOT_PEND  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // One event slot: links carry a valid flag in the top bit
    typedef struct packed {
        logic [LINK_W-1:0]  nxt;
        logic [LINK_W-1:0]  prv;
        logic [DELTA_W-1:0] delta;
        logic [BKT_W-1:0]   bkt;
    } slot_rec_t;

    function automatic logic [LINK_W-1:0] mk_link(input logic [SLOT_W-1:0] idx);
        mk_link = {1'b1, idx};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/hashed_timing_wheel_delta_lists.sv
// Top level: hashed timing wheel with delta-ordered bucket lists.
`default_nettype none
// Hashed timing wheel of 128 buckets over a pool of 32 event slots. One beat is
// accepted at a time; in_stall stays high until its last result has been loaded
// into the output register. A schedule runs a bit-serial divider that turns
// microseconds into ticks, then walks the target bucket's delta list to its
// insertion point; an immediate fire or a full pool ends after the division.
// A cancel unlinks a pending slot (else it reports not pending), and a tick
// unlinks each event that it fires. Output stalls hold up all of these. Events
// fired by one tick come out in list order, the last one marked by last_of_run.
// tick_ms may only be written while the block is idle; zero acts as one.
module hashed_timing_wheel_delta_lists (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [htw_pkg::TICK_W-1:0]  tick_ms,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  req_type,
    input  wire logic [htw_pkg::DELAY_W-1:0] delay_us,
    input  wire logic [htw_pkg::SLOT_W-1:0]  event_handle,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [htw_pkg::SLOT_W-1:0]       slot_id,
    output logic [2:0]                       status,
    output logic                             last_of_run
);
    import htw_pkg::*;

    typedef enum logic [4:0] {
        IDLE, PREP, DIV, SCHED, BRD, WLD, WALK, INS_A, INS_B, INS_C,
        APP_A, APP_B, UNL_A, UNL_B, UNL_C, TK_RD, TK_DEC, TK_RD2, TK_CHK, EMIT
    } state_t;

    state_t                state_reg;
    logic [TICK_W-1:0]     tick_ms_reg;
    logic [BKT_W-1:0]      cur_reg;
    logic [BKT_W-1:0]      bkt_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SLOT_W-1:0]     s_reg;
    logic [SLOT_W-1:0]     tgt_reg;
    logic [DELTA_W-1:0]    d_reg;
    logic [DELTA_W-1:0]    dl_reg;
    logic [LINK_W-1:0]     a_reg;
    logic [LINK_W-1:0]     p_reg;
    logic [LINK_W-1:0]     n_reg;
    logic [BKT_W-1:0]      ub_reg;
    logic [GUARD_W-1:0]    guard_reg;
    logic                  is_tick_reg;
    logic                  held_reg;
    logic [SLOT_W-1:0]     held_id_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SLOT_W-1:0]     res_id_reg;
    status_t               res_st_reg;
    logic [EVENT_SLOTS-1:0] pending_reg;
    slot_rec_t             slot_rec_reg [EVENT_SLOTS];
    logic [BUCKETS-1:0]    first_vld_reg;
    logic [BUCKETS-1:0]    last_vld_reg;
    logic                  rf_vld_reg;
    logic                  rl_vld_reg;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     slot_id_reg;
    status_t               status_reg;
    logic                  last_reg;

    logic [LINK_W-1:0]     rfirst;
    logic [LINK_W-1:0]     rlast;
    logic [LINK_W-1:0]     fhead;
    logic [LINK_W-1:0]     ltail;
    logic [SLOT_W-1:0]     sa;
    slot_rec_t             rec_rd;
    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_wa;
    slot_rec_t             slot_wd;
    logic                  fw_we;
    logic [BKT_W-1:0]      fw_addr;
    logic [LINK_W-1:0]     fw_data;
    logic                  lw_we;
    logic [BKT_W-1:0]      lw_addr;
    logic [LINK_W-1:0]     lw_data;
    logic [TICK_W-1:0]     gran;
    logic [HALF_W-1:0]     half;
    logic [DEN_W:0]        div_trial;
    logic                  div_ge;
    logic [NUM_W-1:0]      ticks_adj;
    logic [DELTA_W-1:0]    rounds;
    logic [BKT_W-1:0]      b_new;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [DELTA_W:0]      dsum;
    logic                  out_free;
    logic                  out_load;
    logic [SLOT_W-1:0]     out_id;
    status_t               out_st;
    logic                  out_last;
    logic                  fire;

    // Bucket head and tail stores
    htw_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_first (
        .clk   (clk),
        .we    (fw_we),
        .waddr (fw_addr),
        .wdata (fw_data),
        .raddr (bkt_reg),
        .rdata (rfirst)
    );

    htw_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_last (
        .clk   (clk),
        .we    (lw_we),
        .waddr (lw_addr),
        .wdata (lw_data),
        .raddr (bkt_reg),
        .rdata (rlast)
    );

    // Mask never-written buckets to empty
    assign fhead = rf_vld_reg ? rfirst : '0;
    assign ltail = rl_vld_reg ? rlast : '0;

    // Tick length and divider step
    assign gran      = (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;
    assign half      = HALF_W'(gran * HALF_W'(HALF_MS));
    assign div_trial = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    // Tick count, round count and target bucket
    always_comb
    begin
        ticks_adj = num_reg;
        if (num_reg == '0 && delay_reg != '0)
        begin
            ticks_adj = NUM_W'(1);
        end
        if (|ticks_adj[NUM_W-1:BKT_W+DELTA_W])
        begin
            rounds = '1;
        end
        else
        begin
            rounds = ticks_adj[BKT_W+DELTA_W-1:BKT_W];
        end
        b_new = cur_reg + ticks_adj[BKT_W-1:0];
    end

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = EVENT_SLOTS - 1; i >= 0; i--)
        begin
            if (!pending_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Select the slot record read this cycle
    always_comb
    begin
        unique case (state_reg)
            WALK, INS_A:         sa = a_reg[SLOT_W-1:0];
            INS_C, APP_B, UNL_C: sa = p_reg[SLOT_W-1:0];
            UNL_B:               sa = n_reg[SLOT_W-1:0];
            TK_DEC, TK_CHK:      sa = fhead[SLOT_W-1:0];
            default:             sa = tgt_reg;
        endcase
    end

    assign rec_rd = slot_rec_reg[sa];
    assign dsum   = {1'b0, rec_rd.delta} + {1'b0, dl_reg};
    assign fire   = fhead[LINK_W-1] && (rec_rd.delta == '0) && (cnt_reg < CNT_W'(MAX_RESULTS));

    // Slot record and bucket store writes
    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = sa;
        slot_wd = rec_rd;
        fw_we   = 1'b0;
        fw_addr = bkt_reg;
        fw_data = mk_link(s_reg);
        lw_we   = 1'b0;
        lw_addr = bkt_reg;
        lw_data = mk_link(s_reg);
        unique case (state_reg)
            INS_A:
            begin
                slot_we       = 1'b1;
                slot_wd.delta = rec_rd.delta - d_reg;
                slot_wd.prv   = mk_link(s_reg);
            end
            INS_B:
            begin
                slot_we = 1'b1;
                slot_wa = s_reg;
                slot_wd = '{nxt: mk_link(a_reg[SLOT_W-1:0]), prv: p_reg,
                            delta: d_reg, bkt: bkt_reg};
            end
            APP_A:
            begin
                slot_we = 1'b1;
                slot_wa = s_reg;
                slot_wd = '{nxt: '0, prv: ltail, delta: d_reg, bkt: bkt_reg};
                lw_we   = 1'b1;
            end
            INS_C, APP_B:
            begin
                if (p_reg[LINK_W-1])
                begin
                    slot_we     = 1'b1;
                    slot_wd.nxt = mk_link(s_reg);
                end
                else
                begin
                    fw_we = 1'b1;
                end
            end
            UNL_B:
            begin
                if (n_reg[LINK_W-1])
                begin
                    slot_we       = 1'b1;
                    slot_wd.delta = dsum[DELTA_W] ? '1 : dsum[DELTA_W-1:0];
                    slot_wd.prv   = p_reg;
                end
                else
                begin
                    lw_we   = 1'b1;
                    lw_addr = ub_reg;
                    lw_data = p_reg;
                end
            end
            UNL_C:
            begin
                if (p_reg[LINK_W-1])
                begin
                    slot_we     = 1'b1;
                    slot_wd.nxt = n_reg;
                end
                else
                begin
                    fw_we   = 1'b1;
                    fw_addr = ub_reg;
                    fw_data = n_reg;
                end
            end
            TK_DEC:
            begin
                if (fhead[LINK_W-1] && rec_rd.delta != '0)
                begin
                    slot_we       = 1'b1;
                    slot_wd.delta = rec_rd.delta - DELTA_W'(1);
                end
            end
            default:
            begin
                slot_we = 1'b0;
            end
        endcase
    end

    // Output register load
    assign out_free = !out_valid_reg || !out_stall;
    always_comb
    begin
        out_load = 1'b0;
        out_id   = res_id_reg;
        out_st   = res_st_reg;
        out_last = 1'b1;
        unique case (state_reg)
            EMIT:
            begin
                out_load = out_free;
            end
            TK_CHK:
            begin
                out_id   = held_id_reg;
                out_st   = ST_FIRED;
                out_last = !fire;
                out_load = held_reg && out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Slot record array
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_rec_reg[slot_wa] <= slot_wd;
        end
    end

    // Sequencer, control state and outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            tick_ms_reg   <= TICK_RESET;
            cur_reg       <= '0;
            bkt_reg       <= '0;
            pending_reg   <= '0;
            first_vld_reg <= '0;
            last_vld_reg  <= '0;
            rf_vld_reg    <= 1'b0;
            rl_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            is_tick_reg   <= 1'b0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            guard_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tick_ms_reg <= tick_ms;
            end

            // Track bucket valid bits alongside the RAM reads
            rf_vld_reg <= first_vld_reg[bkt_reg];
            rl_vld_reg <= last_vld_reg[bkt_reg];
            if (fw_we)
            begin
                first_vld_reg[fw_addr] <= 1'b1;
            end
            if (lw_we)
            begin
                last_vld_reg[lw_addr] <= 1'b1;
            end

            // Drive the output beat
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                slot_id_reg   <= out_id;
                status_reg    <= out_st;
                last_reg      <= out_last;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        delay_reg <= delay_us;
                        unique case (req_t'(req_type))
                            REQ_SCHED:
                            begin
                                state_reg <= PREP;
                            end
                            REQ_CANCEL:
                            begin
                                tgt_reg     <= event_handle;
                                res_id_reg  <= event_handle;
                                is_tick_reg <= 1'b0;
                                if (pending_reg[event_handle])
                                begin
                                    res_st_reg <= ST_CANCELLED;
                                    state_reg  <= UNL_A;
                                end
                                else
                                begin
                                    res_st_reg <= ST_NOT_PEND;
                                    state_reg  <= EMIT;
                                end
                            end
                            REQ_TICK:
                            begin
                                bkt_reg     <= cur_reg;
                                is_tick_reg <= 1'b1;
                                state_reg   <= TK_RD;
                            end
                            REQ_NONE:
                            begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end
                // Form numerator and divisor for the rounding division
                PREP:
                begin
                    num_reg   <= {1'b0, delay_reg} + NUM_W'(half);
                    den_reg   <= {half, 1'b0};
                    rem_reg   <= '0;
                    step_reg  <= STEP_W'(NUM_W - 1);
                    state_reg <= DIV;
                end
                // One quotient bit per cycle
                DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= DEN_W'(div_trial - {1'b0, den_reg});
                    end
                    else
                    begin
                        rem_reg <= div_trial[DEN_W-1:0];
                    end
                    num_reg  <= {num_reg[NUM_W-2:0], div_ge};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= SCHED;
                    end
                end
                SCHED:
                begin
                    if (ticks_adj == '0)
                    begin
                        res_id_reg <= '0;
                        res_st_reg <= ST_FIRED;
                        state_reg  <= EMIT;
                    end
                    else if (!free_found)
                    begin
                        res_id_reg <= '0;
                        res_st_reg <= ST_FULL;
                        state_reg  <= EMIT;
                    end
                    else
                    begin
                        s_reg      <= free_idx;
                        res_id_reg <= free_idx;
                        res_st_reg <= ST_PENDING;
                        d_reg      <= rounds;
                        bkt_reg    <= b_new;
                        state_reg  <= BRD;
                    end
                end
                BRD:
                begin
                    state_reg <= WLD;
                end
                WLD:
                begin
                    a_reg     <= fhead;
                    guard_reg <= '0;
                    state_reg <= WALK;
                end
                // Walk the delta list to the insertion point
                WALK:
                begin
                    if (!a_reg[LINK_W-1] || guard_reg >= GUARD_W'(EVENT_SLOTS))
                    begin
                        state_reg <= APP_A;
                    end
                    else if (rec_rd.delta < d_reg)
                    begin
                        d_reg     <= d_reg - rec_rd.delta;
                        a_reg     <= rec_rd.nxt;
                        guard_reg <= guard_reg + GUARD_W'(1);
                    end
                    else
                    begin
                        state_reg <= INS_A;
                    end
                end
                INS_A:
                begin
                    p_reg     <= rec_rd.prv;
                    state_reg <= INS_B;
                end
                INS_B:
                begin
                    pending_reg[s_reg] <= 1'b1;
                    state_reg          <= INS_C;
                end
                INS_C, APP_B:
                begin
                    state_reg <= EMIT;
                end
                APP_A:
                begin
                    p_reg              <= ltail;
                    pending_reg[s_reg] <= 1'b1;
                    state_reg          <= APP_B;
                end
                // Unlink a slot from its bucket
                UNL_A:
                begin
                    n_reg     <= rec_rd.nxt;
                    p_reg     <= rec_rd.prv;
                    dl_reg    <= rec_rd.delta;
                    ub_reg    <= rec_rd.bkt;
                    state_reg <= UNL_B;
                end
                UNL_B:
                begin
                    state_reg <= UNL_C;
                end
                UNL_C:
                begin
                    pending_reg[tgt_reg] <= 1'b0;
                    state_reg            <= is_tick_reg ? TK_RD2 : EMIT;
                end
                // Tick: age the current bucket, then advance
                TK_RD:
                begin
                    state_reg <= TK_DEC;
                end
                TK_DEC:
                begin
                    cur_reg   <= bkt_reg + BKT_W'(1);
                    bkt_reg   <= bkt_reg + BKT_W'(1);
                    cnt_reg   <= '0;
                    held_reg  <= 1'b0;
                    state_reg <= TK_RD2;
                end
                TK_RD2:
                begin
                    state_reg <= TK_CHK;
                end
                // Fire leading zero-delta slots, holding one back to mark the last
                TK_CHK:
                begin
                    if (!held_reg || out_free)
                    begin
                        if (fire)
                        begin
                            tgt_reg     <= fhead[SLOT_W-1:0];
                            held_id_reg <= fhead[SLOT_W-1:0];
                            held_reg    <= 1'b1;
                            cnt_reg     <= cnt_reg + CNT_W'(1);
                            state_reg   <= UNL_A;
                        end
                        else
                        begin
                            held_reg  <= 1'b0;
                            state_reg <= IDLE;
                        end
                    end
                end
                EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != IDLE);
    assign out_valid   = out_valid_reg;
    assign slot_id     = slot_id_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    // A slot reached while walking a list must be pending
    a_walk_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == WALK && a_reg[LINK_W-1]) |-> pending_reg[a_reg[SLOT_W-1:0]])
        else $error("walked into a slot that is not pending");

    // An inserted slot is pending afterwards
    a_insert_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == INS_B) |=> pending_reg[$past(s_reg)])
        else $error("inserted slot not marked pending");

    // An unlinked slot is free afterwards
    a_unlink_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == UNL_C) |=> !pending_reg[$past(tgt_reg)])
        else $error("unlinked slot still pending");

    // The output register is never overwritten while a stalled beat waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_valid_reg) |-> !out_stall)
        else $error("output beat overwritten while stalled");

endmodule
`default_nettype wire

FILE: hdl/htw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire
